### sv/sbx_pkg.sv
// Shared types, constants and helpers for the sixteen-bit executor.
// Used by sbx_alu, the top level and the testbench; depends on nothing.
package sbx_pkg;

  localparam int MEM_WORDS = 32768;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  localparam logic [3:0] OP_MOV = 4'h1;
  localparam logic [3:0] OP_CMP = 4'h2;
  localparam logic [3:0] OP_ADD = 4'h6;
  localparam logic [3:0] OP_SUB = 4'hE;
  localparam logic [6:0] OP_SOB = 7'o77;
  localparam logic [9:0] OP_ASR = 10'o062;
  localparam logic [9:0] OP_ASL = 10'o063;

  typedef enum logic [2:0] {
    ALU_MOV = 3'd0,
    ALU_CMP = 3'd1,
    ALU_ADD = 3'd2,
    ALU_SUB = 3'd3,
    ALU_ASR = 3'd4,
    ALU_ASL = 3'd5
  } alu_op_e;

  typedef struct packed {
    logic [15:0] r;
    logic [3:0]  flags;
  } alu_res_t;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_RDCMD  = 12'b0000_0000_0100,
    S_FETCH  = 12'b0000_0000_1000,
    S_DECODE = 12'b0000_0001_0000,
    S_OPA    = 12'b0000_0010_0000,
    S_PTRW   = 12'b0000_0100_0000,
    S_IDXW   = 12'b0000_1000_0000,
    S_RDV    = 12'b0001_0000_0000,
    S_VALW   = 12'b0010_0000_0000,
    S_EXEC   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  function automatic logic in_range(input logic [15:0] a);
    in_range = {1'b0, a} < MEM_LIMIT;
  endfunction

endpackage

### sv/sbx_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module sbx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### sv/sbx_alu.sv
// Arithmetic and shift unit with NZVC flag generation.
// Depends on sbx_pkg.
module sbx_alu (
  input  sbx_pkg::alu_op_e  op_i,
  input  logic [15:0]       s_i,
  input  logic [15:0]       d_i,
  input  logic              c_i,
  output sbx_pkg::alu_res_t res_o
);
  logic [16:0] sum;
  logic [15:0] r;
  logic        v;
  logic        c;

  always_comb begin
    sum = 17'(d_i) + 17'(s_i);
    r   = s_i;
    v   = 1'b0;
    c   = c_i;
    case (op_i)
      sbx_pkg::ALU_CMP: begin
        r = s_i - d_i;
        v = (s_i[15] ^ d_i[15]) & (r[15] ^ d_i[15]);
        c = s_i < d_i;
      end
      sbx_pkg::ALU_ADD: begin
        r = sum[15:0];
        v = ~(s_i[15] ^ d_i[15]) & (r[15] ^ s_i[15]);
        c = sum[16];
      end
      sbx_pkg::ALU_SUB: begin
        r = d_i - s_i;
        v = (s_i[15] ^ d_i[15]) & (r[15] ^ s_i[15]);
        c = d_i < s_i;
      end
      sbx_pkg::ALU_ASR: begin
        r = {d_i[15], d_i[15:1]};
        c = d_i[0];
        v = r[15] ^ c;
      end
      sbx_pkg::ALU_ASL: begin
        r = {d_i[14:0], 1'b0};
        c = d_i[15];
        v = r[15] ^ c;
      end
      default: begin
        r = s_i;
      end
    endcase
    res_o.r     = r;
    res_o.flags = {r[15], r == 16'd0, v, c};
  end
endmodule

### sv/sixteen_bit_isa_subset_executor_unit.sv
// Top level of the sixteen-bit instruction-subset executor.
// Depends on sbx_pkg, sbx_ram and sbx_alu.
//
// One request in, one result out. After reset the word memory is cleared, one word
// a cycle, all MEM_WORDS (32768) words, before the first request is taken. Memory
// writes, reads and executes all go through the single memory port, which serves
// fetch, index words, pointers and operands one access per cycle, so an execute
// with memory-deferred indexed operands takes longest and a branch or halt least.
// One request is in flight at a time; the result stays in an output register.
module sixteen_bit_isa_subset_executor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [14:0] address_i,
  input  logic [15:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic [15:0] pc_o,
  output logic [3:0]  flags_o,
  output logic        halted_o,
  output logic [1:0]  status_o
);
  sbx_pkg::state_e state_q, state_d;
  logic [sbx_pkg::AW-1:0] clr_q, clr_d;

  logic [15:0] regs_q [8];
  logic [15:0] wr_q [8];
  logic [15:0] wr_n [8];
  logic [3:0]  flags_q;
  logic        halted_q;

  logic [15:0] ir_q, ir_d;
  logic [5:0]  spec_q, spec_d;
  logic        is_dst_q, is_dst_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [15:0] res_rd_q, res_rd_d;
  logic [1:0]  res_status_q, res_status_d;

  logic        out_valid_q;
  logic [15:0] out_rd_q, out_pc_q;
  logic [3:0]  out_flags_q;
  logic        out_halted_q;
  logic [1:0]  out_status_q;

  logic        mem_we;
  logic [15:0] mem_addr, mem_wdata, mem_rdata;
  logic        rf_we, pc_we, load_w, commit, halt_set, flags_we, out_load;
  logic [2:0]  rf_idx, rsel;
  logic [15:0] rf_val, pc_val, rval, a16, tmp, opv;
  logic [2:0]  mode;
  logic        op_done;
  logic [3:0]  op4;

  sbx_pkg::alu_op_e  alu_op;
  sbx_pkg::alu_res_t alu_res;

  sbx_ram #(.WIDTH(16), .DEPTH(sbx_pkg::MEM_WORDS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr[sbx_pkg::AW-1:0]),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  sbx_alu u_alu (
    .op_i (alu_op),
    .s_i  (src_q),
    .d_i  (dst_q),
    .c_i  (flags_q[0]),
    .res_o(alu_res)
  );

  assign op4  = ir_q[15:12];
  assign mode = spec_q[5:3];
  assign rsel = (state_q == sbx_pkg::S_DECODE) ? ir_q[8:6] : spec_q[2:0];
  assign rval = wr_q[rsel];
  assign a16  = {1'b0, address_i};

  always_comb begin
    case (op4)
      sbx_pkg::OP_MOV: alu_op = sbx_pkg::ALU_MOV;
      sbx_pkg::OP_CMP: alu_op = sbx_pkg::ALU_CMP;
      sbx_pkg::OP_ADD: alu_op = sbx_pkg::ALU_ADD;
      sbx_pkg::OP_SUB: alu_op = sbx_pkg::ALU_SUB;
      default:         alu_op = ir_q[6] ? sbx_pkg::ALU_ASL : sbx_pkg::ALU_ASR;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    ir_d         = ir_q;
    spec_d       = spec_q;
    is_dst_d     = is_dst_q;
    addr_d       = addr_q;
    src_d        = src_q;
    dst_d        = dst_q;
    res_rd_d     = res_rd_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;
    rf_we        = 1'b0;
    rf_idx       = spec_q[2:0];
    rf_val       = '0;
    pc_we        = 1'b0;
    pc_val       = wr_q[7];
    load_w       = 1'b0;
    commit       = 1'b0;
    halt_set     = 1'b0;
    flags_we     = 1'b0;
    out_load     = 1'b0;
    op_done      = 1'b0;
    opv          = '0;
    tmp          = '0;
    unique case (state_q)
      sbx_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = 16'(clr_q);
        clr_d    = clr_q + 1'b1;
        if (clr_q == sbx_pkg::CLR_LAST) begin
          state_d = sbx_pkg::S_IDLE;
        end
      end
      sbx_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_rd_d     = '0;
          res_status_d = sbx_pkg::ST_OK;
          state_d      = sbx_pkg::S_DONE;
          case (command_i)
            sbx_pkg::CMD_WRITE: begin
              if (sbx_pkg::in_range(a16)) begin
                mem_we    = 1'b1;
                mem_addr  = a16;
                mem_wdata = data_i;
              end else begin
                res_status_d = sbx_pkg::ST_BAD;
              end
            end
            sbx_pkg::CMD_READ: begin
              if (sbx_pkg::in_range(a16)) begin
                mem_addr = a16;
                state_d  = sbx_pkg::S_RDCMD;
              end else begin
                res_status_d = sbx_pkg::ST_BAD;
              end
            end
            sbx_pkg::CMD_EXEC: begin
              if (!halted_q) begin
                if (sbx_pkg::in_range(regs_q[7])) begin
                  mem_addr = regs_q[7];
                  load_w   = 1'b1;
                  state_d  = sbx_pkg::S_FETCH;
                end else begin
                  res_status_d = sbx_pkg::ST_BAD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      sbx_pkg::S_RDCMD: begin
        res_rd_d = mem_rdata;
        state_d  = sbx_pkg::S_DONE;
      end
      sbx_pkg::S_FETCH: begin
        ir_d    = mem_rdata;
        pc_we   = 1'b1;
        pc_val  = wr_q[7] + 16'd2;
        state_d = sbx_pkg::S_DECODE;
      end
      sbx_pkg::S_DECODE: begin
        state_d = sbx_pkg::S_DONE;
        if (op4 == sbx_pkg::OP_MOV || op4 == sbx_pkg::OP_CMP ||
            op4 == sbx_pkg::OP_ADD || op4 == sbx_pkg::OP_SUB) begin
          spec_d   = ir_q[11:6];
          is_dst_d = 1'b0;
          state_d  = sbx_pkg::S_OPA;
        end else if (ir_q[15:9] == sbx_pkg::OP_SOB) begin
          tmp    = rval - 16'd1;
          commit = 1'b1;
          if (rsel == 3'd7) begin
            pc_we  = 1'b1;
            pc_val = (tmp != 16'd0) ? tmp - {9'd0, ir_q[5:0], 1'b0} : tmp;
          end else begin
            rf_we  = 1'b1;
            rf_idx = rsel;
            rf_val = tmp;
            if (tmp != 16'd0) begin
              pc_we  = 1'b1;
              pc_val = wr_q[7] - {9'd0, ir_q[5:0], 1'b0};
            end
          end
        end else if (ir_q[15:8] >= 8'd1 && ir_q[15:8] <= 8'd3) begin
          commit = 1'b1;
          if (ir_q[15:8] == 8'd1 || (ir_q[15:8] == 8'd2 && !flags_q[2]) ||
              (ir_q[15:8] == 8'd3 && flags_q[2])) begin
            pc_we  = 1'b1;
            pc_val = wr_q[7] + {{7{ir_q[7]}}, ir_q[7:0], 1'b0};
          end
        end else if (ir_q[15:6] == sbx_pkg::OP_ASR || ir_q[15:6] == sbx_pkg::OP_ASL) begin
          spec_d   = ir_q[5:0];
          is_dst_d = 1'b1;
          state_d  = sbx_pkg::S_OPA;
        end else if (ir_q == 16'd0) begin
          commit   = 1'b1;
          halt_set = 1'b1;
        end else begin
          res_status_d = sbx_pkg::ST_INVALID;
        end
      end
      sbx_pkg::S_OPA: begin
        state_d = sbx_pkg::S_RDV;
        case (mode)
          3'd0: begin
            op_done = 1'b1;
            opv     = rval;
          end
          3'd1: addr_d = rval;
          3'd2: begin
            addr_d = rval;
            rf_we  = 1'b1;
            rf_val = rval + 16'd2;
          end
          3'd3: begin
            rf_we  = 1'b1;
            rf_val = rval + 16'd2;
            if (sbx_pkg::in_range(rval)) begin
              mem_addr = rval;
              state_d  = sbx_pkg::S_PTRW;
            end else begin
              res_status_d = sbx_pkg::ST_BAD;
              state_d      = sbx_pkg::S_DONE;
            end
          end
          3'd4: begin
            tmp    = rval - 16'd2;
            rf_we  = 1'b1;
            rf_val = tmp;
            addr_d = tmp;
          end
          3'd5: begin
            tmp    = rval - 16'd2;
            rf_we  = 1'b1;
            rf_val = tmp;
            if (sbx_pkg::in_range(tmp)) begin
              mem_addr = tmp;
              state_d  = sbx_pkg::S_PTRW;
            end else begin
              res_status_d = sbx_pkg::ST_BAD;
              state_d      = sbx_pkg::S_DONE;
            end
          end
          default: begin
            if (sbx_pkg::in_range(wr_q[7])) begin
              mem_addr = wr_q[7];
              pc_we    = 1'b1;
              pc_val   = wr_q[7] + 16'd2;
              state_d  = sbx_pkg::S_IDXW;
            end else begin
              res_status_d = sbx_pkg::ST_BAD;
              state_d      = sbx_pkg::S_DONE;
            end
          end
        endcase
      end
      sbx_pkg::S_PTRW: begin
        addr_d  = mem_rdata;
        state_d = sbx_pkg::S_RDV;
      end
      sbx_pkg::S_IDXW: begin
        tmp = mem_rdata + rval;
        if (mode == 3'd7) begin
          if (sbx_pkg::in_range(tmp)) begin
            mem_addr = tmp;
            state_d  = sbx_pkg::S_PTRW;
          end else begin
            res_status_d = sbx_pkg::ST_BAD;
            state_d      = sbx_pkg::S_DONE;
          end
        end else begin
          addr_d  = tmp;
          state_d = sbx_pkg::S_RDV;
        end
      end
      sbx_pkg::S_RDV: begin
        if (sbx_pkg::in_range(addr_q)) begin
          mem_addr = addr_q;
          state_d  = sbx_pkg::S_VALW;
        end else begin
          res_status_d = sbx_pkg::ST_BAD;
          state_d      = sbx_pkg::S_DONE;
        end
      end
      sbx_pkg::S_VALW: begin
        op_done = 1'b1;
        opv     = mem_rdata;
      end
      sbx_pkg::S_EXEC: begin
        commit   = 1'b1;
        flags_we = 1'b1;
        state_d  = sbx_pkg::S_DONE;
        if (alu_op != sbx_pkg::ALU_CMP) begin
          if (mode == 3'd0) begin
            rf_we  = 1'b1;
            rf_val = alu_res.r;
          end else if (!(mode == 3'd2 && spec_q[2:0] == 3'd7)) begin
            mem_we    = 1'b1;
            mem_addr  = addr_q;
            mem_wdata = alu_res.r;
          end
        end
      end
      sbx_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = sbx_pkg::S_IDLE;
        end
      end
      default: state_d = sbx_pkg::S_IDLE;
    endcase

    if (op_done) begin
      if (!is_dst_q) begin
        src_d    = opv;
        spec_d   = ir_q[5:0];
        is_dst_d = 1'b1;
        state_d  = sbx_pkg::S_OPA;
      end else begin
        dst_d   = opv;
        state_d = sbx_pkg::S_EXEC;
      end
    end
  end

  always_comb begin
    wr_n = wr_q;
    if (load_w) begin
      wr_n = regs_q;
    end
    if (rf_we) begin
      wr_n[rf_idx] = rf_val;
    end
    if (pc_we) begin
      wr_n[7] = pc_val;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q         <= wr_n;
    ir_q         <= ir_d;
    spec_q       <= spec_d;
    is_dst_q     <= is_dst_d;
    addr_q       <= addr_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    res_rd_q     <= res_rd_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sbx_pkg::S_CLEAR;
      clr_q        <= '0;
      regs_q       <= '{default: '0};
      flags_q      <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_rd_q     <= '0;
      out_pc_q     <= '0;
      out_flags_q  <= '0;
      out_halted_q <= 1'b0;
      out_status_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (commit) begin
        regs_q <= wr_n;
      end
      if (commit && flags_we) begin
        flags_q <= alu_res.flags;
      end
      if (halt_set) begin
        halted_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_rd_q     <= res_rd_q;
        out_pc_q     <= regs_q[7];
        out_flags_q  <= flags_q;
        out_halted_q <= halted_q;
        out_status_q <= res_status_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == sbx_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign pc_o        = out_pc_q;
  assign flags_o     = out_flags_q;
  assign halted_o    = out_halted_q;
  assign status_o    = out_status_q;
endmodule

### sv/sbx_checker.sv
// Port-level checks for the executor top level, bound to it below.
// Depends on sixteen_bit_isa_subset_executor_unit port names.
module sbx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] read_data_o,
  input logic [15:0] pc_o,
  input logic        halted_o,
  input logic [1:0]  status_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pc_o) && $stable(read_data_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(halted_o))
    else $error("halted flag dropped");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> read_data_o == 16'd0)
    else $error("read data on a failed request");
endmodule

bind sixteen_bit_isa_subset_executor_unit sbx_checker u_sbx_checker (.*);

### tb/testbench.sv
// Self-checking testbench for sixteen_bit_isa_subset_executor_unit.
// Drives memory, read and execute requests; predicts every result with its own ISA model.
// Depends on sbx_pkg and the executor RTL.
module testbench;

  localparam int WD_LIMIT = 200000;
  localparam int N_ITEMS  = 1700;

  typedef struct {
    logic [15:0] rd;
    logic [15:0] pc;
    logic [3:0]  flags;
    logic        halted;
    logic [1:0]  status;
  } isa_res_t;

  typedef struct {
    logic [2:0]  mode;
    logic [2:0]  rn;
    logic [15:0] addr;
    logic [15:0] val;
  } opnd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [14:0] address_i = '0;
  logic [15:0] data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] read_data_o;
  logic [15:0] pc_o;
  logic [3:0]  flags_o;
  logic        halted_o;
  logic [1:0]  status_o;

  sixteen_bit_isa_subset_executor_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] mem_m [0:sbx_pkg::MEM_WORDS-1];
  logic [15:0] reg_m [8];
  logic [3:0]  flg_m;
  logic        hlt_m;
  logic        addr_fault;

  isa_res_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int idle_cnt = 0;
  bit hold_req = 0;
  bit tx_burst = 0;
  bit rx_burst = 0;

  function automatic logic [15:0] mem_fetch(input logic [15:0] a);
    if ({1'b0, a} >= sbx_pkg::MEM_LIMIT) begin
      addr_fault = 1'b1;
      return 16'h0;
    end
    return mem_m[a[sbx_pkg::AW-1:0]];
  endfunction

  function automatic void load_opnd(input logic [5:0] spec, output opnd_t o);
    logic [15:0] x;
    logic [15:0] y;
    o.mode = spec[5:3];
    o.rn   = spec[2:0];
    o.addr = 16'h0;
    o.val  = 16'h0;
    case (o.mode)
      3'd0: begin
        o.val = reg_m[o.rn];
        return;
      end
      3'd1: o.addr = reg_m[o.rn];
      3'd2: begin
        o.addr = reg_m[o.rn];
        reg_m[o.rn] = reg_m[o.rn] + 16'd2;
      end
      3'd3: begin
        x = reg_m[o.rn];
        reg_m[o.rn] = reg_m[o.rn] + 16'd2;
        o.addr = mem_fetch(x);
      end
      3'd4: begin
        reg_m[o.rn] = reg_m[o.rn] - 16'd2;
        o.addr = reg_m[o.rn];
      end
      3'd5: begin
        reg_m[o.rn] = reg_m[o.rn] - 16'd2;
        o.addr = mem_fetch(reg_m[o.rn]);
      end
      3'd6: begin
        x = mem_fetch(reg_m[7]);
        reg_m[7] = reg_m[7] + 16'd2;
        o.addr = x + reg_m[o.rn];
      end
      default: begin
        x = mem_fetch(reg_m[7]);
        reg_m[7] = reg_m[7] + 16'd2;
        y = x + reg_m[o.rn];
        o.addr = mem_fetch(y);
      end
    endcase
    o.val = mem_fetch(o.addr);
  endfunction

  function automatic sbx_pkg::status_e run_ins();
    logic [15:0] saved [8];
    logic [3:0]  sflg;
    logic [15:0] ins, s, d, r, off, vx;
    logic        vf, cf, n, take, invalid, do_store;
    logic [2:0]  ri;
    logic [7:0]  kind;
    opnd_t so, dso;
    if ({1'b0, reg_m[7]} >= sbx_pkg::MEM_LIMIT) return sbx_pkg::ST_BAD;
    saved = reg_m;
    sflg = flg_m;
    addr_fault = 1'b0;
    invalid = 1'b0;
    do_store = 1'b0;
    dso = '{default: '0};
    ins = mem_m[reg_m[7][sbx_pkg::AW-1:0]];
    reg_m[7] = reg_m[7] + 16'd2;
    if (ins[15:12] == sbx_pkg::OP_MOV || ins[15:12] == sbx_pkg::OP_CMP ||
        ins[15:12] == sbx_pkg::OP_ADD || ins[15:12] == sbx_pkg::OP_SUB) begin
      load_opnd(ins[11:6], so);
      load_opnd(ins[5:0], dso);
      s = so.val;
      d = dso.val;
      case (ins[15:12])
        sbx_pkg::OP_MOV: begin
          dso.val = s;
          flg_m = {s[15], s == 16'h0, 1'b0, flg_m[0]};
          do_store = 1'b1;
        end
        sbx_pkg::OP_CMP: begin
          r = s - d;
          vx = (s ^ d) & (r ^ d);
          vf = vx[15];
          flg_m = {r[15], r == 16'h0, vf, s < d};
        end
        sbx_pkg::OP_ADD: begin
          r = d + s;
          vx = ~(s ^ d) & (r ^ s);
          vf = vx[15];
          flg_m = {r[15], r == 16'h0, vf, r < d};
          dso.val = r;
          do_store = 1'b1;
        end
        default: begin
          r = d - s;
          vx = (s ^ d) & (r ^ s);
          vf = vx[15];
          flg_m = {r[15], r == 16'h0, vf, d < s};
          dso.val = r;
          do_store = 1'b1;
        end
      endcase
    end else if (ins[15:9] == sbx_pkg::OP_SOB) begin
      ri = ins[8:6];
      reg_m[ri] = reg_m[ri] - 16'd1;
      if (reg_m[ri] != 16'h0) reg_m[7] = reg_m[7] - {9'h0, ins[5:0], 1'b0};
    end else if (ins[15:8] >= 8'd1 && ins[15:8] <= 8'd3) begin
      kind = ins[15:8];
      take = (kind == 8'd1) || (kind == 8'd2 && !flg_m[2]) || (kind == 8'd3 && flg_m[2]);
      off = {{8{ins[7]}}, ins[7:0]};
      if (take) reg_m[7] = reg_m[7] + {off[14:0], 1'b0};
    end else if (ins[15:6] == sbx_pkg::OP_ASR || ins[15:6] == sbx_pkg::OP_ASL) begin
      load_opnd(ins[5:0], dso);
      d = dso.val;
      if (ins[15:6] == sbx_pkg::OP_ASR) begin
        cf = d[0];
        r = {d[15], d[15:1]};
      end else begin
        cf = d[15];
        r = {d[14:0], 1'b0};
      end
      n = r[15];
      flg_m = {n, r == 16'h0, n ^ cf, cf};
      dso.val = r;
      do_store = 1'b1;
    end else if (ins == 16'h0) begin
      hlt_m = 1'b1;
    end else begin
      invalid = 1'b1;
    end
    if (invalid || addr_fault) begin
      reg_m = saved;
      flg_m = sflg;
      hlt_m = 1'b0;
      return invalid ? sbx_pkg::ST_INVALID : sbx_pkg::ST_BAD;
    end
    if (do_store) begin
      if (dso.mode == 3'd0) reg_m[dso.rn] = dso.val;
      else if (!(dso.mode == 3'd2 && dso.rn == 3'd7) && sbx_pkg::in_range(dso.addr))
        mem_m[dso.addr[sbx_pkg::AW-1:0]] = dso.val;
    end
    return sbx_pkg::ST_OK;
  endfunction

  function automatic isa_res_t isa_step(input logic [1:0] c, input logic [14:0] a,
                                        input logic [15:0] dw);
    isa_res_t res;
    res.rd = 16'h0;
    res.status = sbx_pkg::ST_OK;
    if (c == sbx_pkg::CMD_WRITE) mem_m[a] = dw;
    else if (c == sbx_pkg::CMD_READ) res.rd = mem_m[a];
    else if (c == sbx_pkg::CMD_EXEC && !hlt_m) res.status = run_ins();
    res.pc = reg_m[7];
    res.flags = flg_m;
    res.halted = hlt_m;
    return res;
  endfunction

  task automatic send_req(input logic [1:0] c, input logic [14:0] a, input logic [15:0] dw);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : int'($urandom_range(0, 16));
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= c;
    address_i  <= a;
    data_i     <= dw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(isa_step(c, a, dw));
    sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_at_pc(input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2);
    logic [15:0] p;
    p = reg_m[7];
    send_req(sbx_pkg::CMD_WRITE, p[14:0], w0);
    send_req(sbx_pkg::CMD_WRITE, 15'(p + 16'd2), w1);
    send_req(sbx_pkg::CMD_WRITE, 15'(p + 16'd4), w2);
    send_req(sbx_pkg::CMD_EXEC, 15'($urandom), 16'($urandom));
  endtask

  function automatic logic [5:0] rand_spec(input bit is_dst);
    logic [5:0] sp;
    sp = 6'($urandom);
    if (is_dst && sp == 6'o07) sp = 6'o00;
    return sp;
  endfunction

  function automatic bit pc_hazard(input logic [15:0] w);
    if (w == 16'h0) return 1;
    if ((w[15:12] == sbx_pkg::OP_MOV || w[15:12] == sbx_pkg::OP_ADD ||
         w[15:12] == sbx_pkg::OP_SUB) && w[5:0] == 6'o07)
      return 1;
    if ((w[15:6] == sbx_pkg::OP_ASR || w[15:6] == sbx_pkg::OP_ASL) && w[5:0] == 6'o07)
      return 1;
    return 0;
  endfunction

  function automatic logic [15:0] rand_ext();
    if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 200)) + 16'h4000;
    return 16'($urandom);
  endfunction

  task automatic test_memory_access();
    send_req(sbx_pkg::CMD_WRITE, 15'h0, 16'hFFFF);
    send_req(sbx_pkg::CMD_WRITE, 15'h7FFF, 16'hA5A5);
    send_req(sbx_pkg::CMD_READ, 15'h0, 16'h0);
    send_req(sbx_pkg::CMD_READ, 15'h7FFF, 16'hFFFF);
    send_req(sbx_pkg::CMD_WRITE, 15'h0, 16'h0);
    send_req(2'd3, 15'h5555, 16'h1234);
  endtask

  task automatic test_instructions();
    run_at_pc(16'o012701, 16'h8000, 16'h0);
    run_at_pc(16'o012702, 16'h0, 16'h0);
    run_at_pc(16'o060101, 16'h0, 16'h0);
    run_at_pc(16'o160201, 16'h0, 16'h0);
    run_at_pc(16'o020102, 16'h0, 16'h0);
    run_at_pc(16'o012703, 16'h4000, 16'h0);
    run_at_pc(16'o010113, 16'h0, 16'h0);
    run_at_pc(16'o062301, 16'h0, 16'h0);
    run_at_pc(16'o164302, 16'h0, 16'h0);
    run_at_pc(16'o023300, 16'h0, 16'h0);
    run_at_pc(16'o006353, 16'h0, 16'h0);
    run_at_pc(16'o006263, 16'd4, 16'h0);
    run_at_pc(16'o067300, 16'd2, 16'h0);
    run_at_pc(16'o016700, 16'd10, 16'h0);
    run_at_pc(16'o017700, 16'd6, 16'h0);
    run_at_pc(16'o013705, 16'h4000, 16'h0);
    run_at_pc(16'o010027, 16'd5, 16'h0);
    run_at_pc(16'o006205, 16'h0, 16'h0);
    run_at_pc(16'o006305, 16'h0, 16'h0);
    run_at_pc(16'o000401, 16'h0, 16'h0);
    run_at_pc(16'o001001, 16'h0, 16'h0);
    run_at_pc(16'o001777, 16'h0, 16'h0);
    run_at_pc(16'o077000, 16'h0, 16'h0);
    run_at_pc(16'o077402, 16'h0, 16'h0);
    run_at_pc(16'h7000, 16'h0, 16'h0);
    run_at_pc(16'o013700, 16'h8000, 16'h0);
    wait_drain();
  endtask

  task automatic test_random_programs();
    logic [15:0] w;
    hold_req = 1;
    while (sent < N_ITEMS) begin
      if (reg_m[7] < 16'd600 || reg_m[7] > 16'd32000)
        run_at_pc(16'o012707, 16'($urandom_range(1024, 30000)), 16'h0);
      case ($urandom_range(0, 19))
        0, 1: send_req(2'($urandom_range(0, 3)), 15'($urandom), 16'($urandom));
        2: send_req(sbx_pkg::CMD_READ, 15'(reg_m[$urandom_range(0, 6)]), 16'($urandom));
        3: begin
          do w = 16'($urandom); while (pc_hazard(w));
          run_at_pc(w, rand_ext(), rand_ext());
        end
        4, 5: run_at_pc({10'o0127, 3'd2, 3'($urandom_range(0, 6))}, rand_ext(), 16'h0);
        6: run_at_pc({7'o77, 3'($urandom), 6'($urandom)}, 16'h0, 16'h0);
        7: run_at_pc({8'($urandom_range(1, 3)), 8'($urandom)}, 16'h0, 16'h0);
        8, 9: run_at_pc({($urandom_range(0, 1) != 0) ? sbx_pkg::OP_ASR : sbx_pkg::OP_ASL,
                         rand_spec(1)}, rand_ext(), rand_ext());
        default: begin
          case ($urandom_range(0, 3))
            0: w[15:12] = sbx_pkg::OP_MOV;
            1: w[15:12] = sbx_pkg::OP_CMP;
            2: w[15:12] = sbx_pkg::OP_ADD;
            default: w[15:12] = sbx_pkg::OP_SUB;
          endcase
          w[11:0] = {rand_spec(0), rand_spec(1)};
          run_at_pc(w, rand_ext(), rand_ext());
        end
      endcase
    end
  endtask

  task automatic test_terminal_state();
    if ($urandom_range(0, 1) != 0) begin
      run_at_pc(16'o012707, 16'h8000, 16'h0);
      send_req(sbx_pkg::CMD_EXEC, 15'h0, 16'h0);
    end else begin
      run_at_pc(16'h0, 16'h0, 16'h0);
      send_req(sbx_pkg::CMD_EXEC, 15'h0, 16'h0);
    end
    send_req(sbx_pkg::CMD_READ, 15'h7FFF, 16'h0);
  endtask

  initial begin
    for (int i = 0; i < sbx_pkg::MEM_WORDS; i++) mem_m[i] = 16'h0;
    for (int i = 0; i < 8; i++) reg_m[i] = 16'h0;
    flg_m = 4'h0;
    hlt_m = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_memory_access();
    test_instructions();
    test_random_programs();
    test_terminal_state();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (expected_q.size() != 0) errors++;
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : int'($urandom_range(0, 16));
      if (hold_req) begin
        gap = 400;
        hold_req = 0;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pc=%h status=%0d", pc_o, status_o);
      end else begin
        isa_res_t e;
        e = expected_q.pop_front();
        if (e.rd !== read_data_o || e.pc !== pc_o || e.flags !== flags_o ||
            e.halted !== halted_o || e.status !== status_o) begin
          errors++;
          if (errors <= 10)
            $display("exp rd=%h pc=%h f=%h h=%b st=%0d  got rd=%h pc=%h f=%h h=%b st=%0d",
                     e.rd, e.pc, e.flags, e.halted, e.status,
                     read_data_o, pc_o, flags_o, halted_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
